### design/cspf_pkg.sv
// Shared types, constants and CRC7 step for the sample page framer.
package cspf_pkg;

   localparam int SampleW    = 14;
   localparam int AddrW      = 14;
   localparam int ByteW      = 7;
   localparam int SubW       = 4;
   localparam int QueueDepth = 4;
   localparam int QPtrW      = 2;
   localparam int QCntW      = 3;
   localparam int ReqDataW   = 32;
   localparam int RspDataW   = 8;
   localparam int RspUserW   = 2;

   typedef struct packed {
      logic [SampleW-1:0] sample;
      logic [AddrW-1:0]   address;
      logic [SubW-1:0]    subpacket;
      logic               first;
      logic               last;
      logic               page_last;
   } desc_type;

   function automatic logic [ByteW-1:0] header_byte(input logic [2:0] idx);
      logic [ByteW-1:0] b;
      unique case (idx)
         3'd0:    b = 7'h00;
         3'd1:    b = 7'h21;
         3'd2:    b = 7'h0b;
         3'd3:    b = 7'h04;
         3'd4:    b = 7'h00;
         3'd5:    b = 7'h05;
         default: b = 7'h00;
      endcase
      return b;
   endfunction

   function automatic logic [ByteW-1:0] crc7_step(input logic [ByteW-1:0] crc,
                                                  input logic [ByteW-1:0] d);
      logic [7:0] t;
      t = {1'b0, d} ^ {crc, 1'b0};
      if (t[7]) begin
         t = t ^ 8'h09;
      end
      return t[6:0] ^ (crc & 7'h78) ^ {crc[2:0], 4'b0000} ^ {3'b000, crc[6:3]};
   endfunction

endpackage

### design/cspf_front.sv
// Front end: accepts samples, tracks page and subpacket position, builds descriptors.
module cspf_front #(
   parameter int SUBPACKETS_PER_PAGE   = 11,
   parameter int SAMPLES_PER_SUBPACKET = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [cspf_pkg::SampleW-1:0]   in_sample,
   input  logic [cspf_pkg::AddrW-1:0]     in_address,
   output logic                           in_ready,
   output logic                           push,
   output cspf_pkg::desc_type             push_desc,
   input  logic                           queue_full
);

   localparam int PosW = (SAMPLES_PER_SUBPACKET > 1) ? $clog2(SAMPLES_PER_SUBPACKET) : 1;
   localparam logic [PosW-1:0] PosLast = PosW'(SAMPLES_PER_SUBPACKET - 1);
   localparam logic [cspf_pkg::SubW-1:0] SubLast = cspf_pkg::SubW'(SUBPACKETS_PER_PAGE - 1);

   logic [PosW-1:0]               pos_ff, pos_in;
   logic [cspf_pkg::SubW-1:0]     sub_ff, sub_in;
   logic [cspf_pkg::AddrW-1:0]    addr_ff, addr_in;
   logic                          first, last, page_last;

   assign in_ready  = !queue_full;
   assign push      = in_valid && in_ready;
   assign first     = (pos_ff == '0);
   assign last      = (pos_ff == PosLast);
   assign page_last = (sub_ff == SubLast);

   always_comb begin
      pos_in  = pos_ff;
      sub_in  = sub_ff;
      addr_in = addr_ff;
      if (push) begin
         if (first && sub_ff == '0) begin
            addr_in = in_address;
         end
         if (last) begin
            pos_in = '0;
            sub_in = page_last ? '0 : sub_ff + 1'b1;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   assign push_desc.sample    = in_sample;
   assign push_desc.address   = addr_in;
   assign push_desc.subpacket = sub_ff;
   assign push_desc.first     = first;
   assign push_desc.last      = last;
   assign push_desc.page_last = page_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         sub_ff  <= '0;
         addr_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         sub_ff  <= sub_in;
         addr_ff <= addr_in;
      end
   end

endmodule

### design/cspf_queue.sv
// Four-entry descriptor queue between front and back ends.
module cspf_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cspf_pkg::desc_type  push_desc,
   output logic                full,
   output logic                head_valid,
   output cspf_pkg::desc_type  head_desc,
   input  logic                pop
);

   cspf_pkg::desc_type                entry_ff [cspf_pkg::QueueDepth];
   logic [cspf_pkg::QPtrW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [cspf_pkg::QPtrW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [cspf_pkg::QCntW-1:0]        count_ff, count_in;

   assign full       = (count_ff == cspf_pkg::QCntW'(cspf_pkg::QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_desc  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + cspf_pkg::QCntW'(push) - cspf_pkg::QCntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### design/cspf_back.sv
// Back end: byte sequencer, running CRC7 and output register.
module cspf_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         head_valid,
   input  cspf_pkg::desc_type           head_desc,
   output logic                         pop,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [cspf_pkg::ByteW-1:0]   out_byte,
   output logic                         out_last,
   output logic                         out_sub_end,
   output logic                         out_page_end
);

   localparam logic [3:0] StepHdrFirst = 4'd0;
   localparam logic [3:0] StepHdrLast  = 4'd5;
   localparam logic [3:0] StepAddrLo   = 4'd6;
   localparam logic [3:0] StepAddrHi   = 4'd7;
   localparam logic [3:0] StepSubNum   = 4'd8;
   localparam logic [3:0] StepSampLo   = 4'd9;
   localparam logic [3:0] StepSampHi   = 4'd10;
   localparam logic [3:0] StepCrc      = 4'd11;

   logic [3:0]                  step_ff, step_in, cur;
   logic                        active_ff, active_in;
   logic [cspf_pkg::ByteW-1:0]  crc_ff, crc_in, crc_base, next_byte;
   logic [cspf_pkg::ByteW-1:0]  byte_ff;
   logic                        valid_ff, valid_in, last_ff, sub_end_ff, page_end_ff;
   logic                        load, final_byte;

   assign cur        = active_ff ? step_ff : (head_desc.first ? StepHdrFirst : StepSampLo);
   assign load       = head_valid && (!valid_ff || out_ready);
   assign final_byte = (cur == (head_desc.last ? StepCrc : StepSampHi));
   assign pop        = load && final_byte;

   always_comb begin
      if (cur <= StepHdrLast) begin
         next_byte = cspf_pkg::header_byte(cur[2:0]);
      end else begin
         unique case (cur)
            StepAddrLo: next_byte = head_desc.address[6:0];
            StepAddrHi: next_byte = head_desc.address[13:7];
            StepSubNum: next_byte = {3'b000, head_desc.subpacket};
            StepSampLo: next_byte = head_desc.sample[6:0];
            StepSampHi: next_byte = head_desc.sample[13:7];
            StepCrc:    next_byte = crc_ff;
            default:    next_byte = '0;
         endcase
      end
   end

   always_comb begin
      crc_base  = (cur == StepHdrFirst) ? '0 : crc_ff;
      crc_in    = crc_ff;
      step_in   = step_ff;
      active_in = active_ff;
      valid_in  = valid_ff && !out_ready;
      if (load) begin
         valid_in = 1'b1;
         if (cur != StepCrc) begin
            crc_in = cspf_pkg::crc7_step(crc_base, next_byte);
         end
         if (final_byte) begin
            active_in = 1'b0;
         end else begin
            active_in = 1'b1;
            step_in   = cur + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff     <= next_byte;
         last_ff     <= final_byte;
         sub_end_ff  <= (cur == StepCrc);
         page_end_ff <= (cur == StepCrc) && head_desc.page_last;
      end
      crc_ff  <= crc_in;
      step_ff <= step_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
   end

   assign out_valid    = valid_ff;
   assign out_byte     = byte_ff;
   assign out_last     = last_ff;
   assign out_sub_end  = sub_end_ff;
   assign out_page_end = page_end_ff;

endmodule

### design/crc7_sample_page_framer_unit.sv
// Top level of the CRC7 sample page framer.
//
//  channel  dir  transfer                  payload
//  req_     in   one 14-bit sample         tdata: sample, page_address
//  rsp_     out  one 7-bit payload byte    tdata: data_byte; tlast; tuser: sub/page end
//
// An item yields 2 bytes, 3 on the last sample of a subpacket, 11 on the first
// (12 if both), one byte per cycle from the back-end sequencer into the rsp register.
// Reset is synchronous and clears position counters, queue and output valid.
// req_tready drops only while the four-entry descriptor queue is full;
// a stall on rsp_ freezes the back end while the front keeps filling the queue.
module crc7_sample_page_framer_unit #(
   parameter int SUBPACKETS_PER_PAGE   = 11,
   parameter int SAMPLES_PER_SUBPACKET = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [cspf_pkg::ReqDataW-1:0]   req_tdata,  // sample[13:0], page_address[27:14]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [cspf_pkg::RspDataW-1:0]   rsp_tdata,  // data_byte[6:0]
   output logic                            rsp_tlast,
   output logic [cspf_pkg::RspUserW-1:0]   rsp_tuser   // subpacket_end[0], page_end[1]
);

   logic               push, full, head_valid, pop;
   cspf_pkg::desc_type push_desc, head_desc;
   logic [cspf_pkg::ByteW-1:0] data_byte;
   logic               sub_end, page_end;

   cspf_front #(
      .SUBPACKETS_PER_PAGE   (SUBPACKETS_PER_PAGE),
      .SAMPLES_PER_SUBPACKET (SAMPLES_PER_SUBPACKET)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_sample  (req_tdata[13:0]),
      .in_address (req_tdata[27:14]),
      .in_ready   (req_tready),
      .push       (push),
      .push_desc  (push_desc),
      .queue_full (full)
   );

   cspf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_desc  (push_desc),
      .full       (full),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .pop        (pop)
   );

   cspf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_desc    (head_desc),
      .pop          (pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_byte     (data_byte),
      .out_last     (rsp_tlast),
      .out_sub_end  (sub_end),
      .out_page_end (page_end)
   );

   assign rsp_tdata = {1'b0, data_byte};
   assign rsp_tuser = {page_end, sub_end};

endmodule

### design/cspf_checker.sv
// Port-level checker for the sample page framer, bound to the top level.
module cspf_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [cspf_pkg::ReqDataW-1:0]   req_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [cspf_pkg::RspDataW-1:0]   rsp_tdata,
   input logic                            rsp_tlast,
   input logic [cspf_pkg::RspUserW-1:0]   rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("rsp transfer changed while stalled");

   a_page_in_sub: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("page end without subpacket end");

   a_crc_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("CRC byte not last of item");

   a_seven_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[7])
      else $error("payload byte exceeds 7 bits");

endmodule

bind crc7_sample_page_framer_unit cspf_checker u_cspf_checker (.*);

### tb/sv/crc7_sample_page_framer_unit_tb.sv
// CRC7 sample page framer testbench: directed and random stream traffic checked by a byte predictor.
`timescale 1ns / 100ps

module crc7_sample_page_framer_unit_tb;

   localparam int SUBS         = 11;
   localparam int SAMPLES      = 24;
   localparam int PAGE_ITEMS   = SUBS * SAMPLES;
   localparam int DIRECTED_N   = 20;
   localparam int RANDOM_N     = 380;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 24;

   localparam bit [cspf_pkg::ByteW-1:0] HEADER_BYTES [6] =
      '{7'h00, 7'h21, 7'h0b, 7'h04, 7'h00, 7'h05};

   typedef struct {
      bit [cspf_pkg::ByteW-1:0] data;
      bit                       last;
      bit                       sub_end;
      bit                       page_end;
   } framed_byte_type;

   class framed_byte_scoreboard;
      framed_byte_type          expected_bytes[$];
      bit [8:0]                 pos_in_sub;
      bit [cspf_pkg::SubW-1:0]  sub_index;
      bit [cspf_pkg::ByteW-1:0] crc_acc;
      bit [cspf_pkg::AddrW-1:0] held_addr;
      int                       errors;

      function bit [cspf_pkg::ByteW-1:0] crc7_next(bit [cspf_pkg::ByteW-1:0] crc,
                                                   bit [cspf_pkg::ByteW-1:0] d);
         bit [7:0]                 mix;
         bit [cspf_pkg::ByteW-1:0] shifted_up;
         bit [cspf_pkg::ByteW-1:0] shifted_down;
         mix = {crc, 1'b0} ^ {1'b0, d};
         if (mix[7]) begin
            mix = mix ^ 8'h09;
         end
         shifted_up   = {crc[2:0], 4'h0};
         shifted_down = {3'h0, crc[6:3]};
         return mix[6:0] ^ (crc & 7'h78) ^ shifted_up ^ shifted_down;
      endfunction

      function void push_byte(bit [cspf_pkg::ByteW-1:0] b, bit se, bit pe);
         framed_byte_type fb;
         fb.data     = b;
         fb.last     = 1'b0;
         fb.sub_end  = se;
         fb.page_end = pe;
         expected_bytes.push_back(fb);
         if (!se) begin
            crc_acc = crc7_next(crc_acc, b);
         end
      endfunction

      // Predicts every byte that one accepted sample produces.
      function void frame_sample(bit [cspf_pkg::SampleW-1:0] s, bit [cspf_pkg::AddrW-1:0] a);
         bit last_sub;
         if (pos_in_sub == 0) begin
            if (sub_index == 0) begin
               held_addr = a;
            end
            crc_acc = '0;
            for (int i = 0; i < 6; i++) begin
               push_byte(HEADER_BYTES[i], 1'b0, 1'b0);
            end
            push_byte(held_addr[6:0], 1'b0, 1'b0);
            push_byte(held_addr[13:7], 1'b0, 1'b0);
            push_byte({3'h0, sub_index}, 1'b0, 1'b0);
         end
         push_byte(s[6:0], 1'b0, 1'b0);
         push_byte(s[13:7], 1'b0, 1'b0);
         pos_in_sub = pos_in_sub + 1'b1;
         if (pos_in_sub >= SAMPLES) begin
            last_sub = (sub_index + 1 >= SUBS);
            push_byte(crc_acc, 1'b1, last_sub);
            pos_in_sub = '0;
            crc_acc    = '0;
            sub_index  = last_sub ? '0 : sub_index + 1'b1;
         end
         expected_bytes[$].last = 1'b1;
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         errors++;
      endtask

      task check_byte(bit [cspf_pkg::ByteW-1:0] d, bit l, bit se, bit pe);
         framed_byte_type fb;
         if (expected_bytes.size() == 0) begin
            report($sformatf("byte %h arrived with nothing pending", d));
         end else begin
            fb = expected_bytes.pop_front();
            if (d !== fb.data) begin
               report($sformatf("data_byte %h, expected %h", d, fb.data));
            end
            if (l !== fb.last) begin
               report($sformatf("last_of_run %b, expected %b (byte %h)", l, fb.last, fb.data));
            end
            if (se !== fb.sub_end) begin
               report($sformatf("subpacket_end %b, expected %b (byte %h)", se, fb.sub_end,
                                fb.data));
            end
            if (pe !== fb.page_end) begin
               report($sformatf("page_end %b, expected %b (byte %h)", pe, fb.page_end,
                                fb.data));
            end
         end
      endtask

      function int waiting();
         return expected_bytes.size();
      endfunction
   endclass

   logic                          clock;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   logic [cspf_pkg::ReqDataW-1:0] req_tdata;   // sample[13:0], page_address[27:14]
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   logic [cspf_pkg::RspDataW-1:0] rsp_tdata;   // data_byte[6:0]
   logic                          rsp_tlast;
   logic [cspf_pkg::RspUserW-1:0] rsp_tuser;   // subpacket_end[0], page_end[1]

   framed_byte_scoreboard sb;
   int                    idle_cycles;

   crc7_sample_page_framer_unit #(
      .SUBPACKETS_PER_PAGE  (SUBS),
      .SAMPLES_PER_SUBPACKET(SAMPLES)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int draw_wait(bit calm);
      return calm ? 0 : $urandom_range(0, 15);
   endfunction

   task send_sample(input bit [cspf_pkg::SampleW-1:0] s, input bit [cspf_pkg::AddrW-1:0] a,
                    input int gap);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {4'h0, a, s};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.frame_sample(s, a);
   endtask

   // Holds the request side off until every predicted byte has drained.
   task drain_pause();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.waiting() > 0) @(negedge clock);
   endtask

   task receive_bytes();
      int  count;
      int  stall;
      bit  calm;
      count = 0;
      calm  = 1'b0;
      forever begin
         if (count % 48 == 0) begin
            calm = ($urandom_range(0, 2) == 0);
         end
         stall = draw_wait(calm);
         if (stall > 0) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         sb.check_byte(rsp_tdata[cspf_pkg::ByteW-1:0], rsp_tlast, rsp_tuser[0], rsp_tuser[1]);
         count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("crc7_sample_page_framer_unit test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      bit [cspf_pkg::SampleW-1:0] directed_samples [DIRECTED_N];
      bit [cspf_pkg::AddrW-1:0]   addr;
      bit                         calm;
      int                         item;
      sb          = new;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      directed_samples = '{14'h3fff, 14'h0000, 14'h3fff, 14'h2aaa, 14'h1555, 14'h007f,
                           14'h3f80, 14'h0001, 14'h2000, 14'h0080, 14'h0040, 14'h3fff,
                           14'h0000, 14'h1234, 14'h2edc, 14'h3ffe, 14'h0055, 14'h2a80,
                           14'h1fff, 14'h2000};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      fork
         receive_bytes();
      join_none

      // page address taken on the opening sample only; later addresses must be ignored
      for (item = 0; item < DIRECTED_N; item++) begin
         if (item == 0) begin
            addr = 14'h3fff;
         end else begin
            addr = (item % 2) ? 14'h0000 : 14'h2aaa;
         end
         send_sample(directed_samples[item], addr, (item < 10) ? 0 : item % 4);
      end
      drain_pause();

      calm = 1'b0;
      for (item = DIRECTED_N; item < DIRECTED_N + RANDOM_N; item++) begin
         if (item % 40 == 0) begin
            calm = ($urandom_range(0, 2) == 0);
         end
         addr = cspf_pkg::AddrW'($urandom_range(0, 16383));
         if (item == PAGE_ITEMS) begin
            addr = 14'h0000;
         end
         if (item == 300) begin
            drain_pause();
         end
         send_sample(cspf_pkg::SampleW'($urandom_range(0, 16383)), addr, draw_wait(calm));
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (sb.waiting() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.waiting() == 0) begin
         $display("crc7_sample_page_framer_unit test passed");
      end else begin
         $display("crc7_sample_page_framer_unit test failed");
      end
      $finish;
   end

endmodule

### files.f
design/cspf_pkg.sv
design/cspf_front.sv
design/cspf_queue.sv
design/cspf_back.sv
design/crc7_sample_page_framer_unit.sv
design/cspf_checker.sv
tb/sv/crc7_sample_page_framer_unit_tb.sv
